// ===== rtl/spirograph_point_generator_defines.svh =====
// Assertion macros for the spirograph point generator checker.
// Included by the checker file only.
`ifndef SPIROGRAPH_POINT_GENERATOR_DEFINES_SVH
`define SPIROGRAPH_POINT_GENERATOR_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SPG_ASSERT_IMPL(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) else $error(msg);
// Next-cycle implication checked outside reset.
`define SPG_ASSERT_NEXT(label, clk, rst_n, lhs, rhs, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) else $error(msg);
`endif

// ===== rtl/spg_pkg.sv =====
// Shared types and constants of the spirograph point generator.
// No dependencies.
package spg_pkg;
  localparam int NumPens     = 2;
  localparam int CordicSteps = 18;
  localparam int IdxW        = $clog2(CordicSteps);

  typedef enum logic [3:0] {
    CFG_MODE_INSIDE   = 4'd0,
    CFG_PARENT_RADIUS = 4'd1,
    CFG_CHILD_RADIUS  = 4'd2,
    CFG_CHILD_SPEED   = 4'd3,
    CFG_PARENT_SPEED  = 4'd4,
    CFG_SPEED_FACTOR  = 4'd5,
    CFG_PEN_RADIUS_A  = 4'd6,
    CFG_PEN_RADIUS_B  = 4'd7
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ADV, ST_DIV, ST_PD1, ST_PD2, ST_ROT, ST_OUT
  } state_t;

  typedef struct packed {
    logic               start;
    logic signed [17:0] radius;
    logic [15:0]        angle;
  } rot_req_t;

  typedef struct packed {
    logic               done;
    logic signed [21:0] x;
    logic signed [21:0] y;
  } rot_rsp_t;

  function automatic logic [31:0] atan_lut(input logic [IdxW-1:0] i);
    case (i)
      5'd0:  atan_lut = 32'd536870912;
      5'd1:  atan_lut = 32'd316933406;
      5'd2:  atan_lut = 32'd167458908;
      5'd3:  atan_lut = 32'd85004756;
      5'd4:  atan_lut = 32'd42667338;
      5'd5:  atan_lut = 32'd21354465;
      5'd6:  atan_lut = 32'd10679838;
      5'd7:  atan_lut = 32'd5340245;
      5'd8:  atan_lut = 32'd2670163;
      5'd9:  atan_lut = 32'd1335087;
      5'd10: atan_lut = 32'd667544;
      5'd11: atan_lut = 32'd333772;
      5'd12: atan_lut = 32'd166886;
      5'd13: atan_lut = 32'd83443;
      5'd14: atan_lut = 32'd41722;
      5'd15: atan_lut = 32'd20861;
      5'd16: atan_lut = 32'd10430;
      5'd17: atan_lut = 32'd5215;
      default: atan_lut = 32'd0;
    endcase
  endfunction

  function automatic logic signed [19:0] sat20(input logic signed [23:0] v);
    if (v > 24'sd524287) sat20 = 20'sd524287;
    else if (v < -24'sd524288) sat20 = -20'sd524288;
    else sat20 = v[19:0];
  endfunction
endpackage

// ===== rtl/spg_cordic.sv =====
// Iterative CORDIC rotator: one micro-rotation per cycle, 18 steps.
// Depends on spg_pkg.
module spg_cordic import spg_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  rot_req_t req,
  output rot_rsp_t rsp
);
  logic signed [35:0] x_r, y_r, x_nxt, y_nxt;
  logic signed [32:0] z_r, z_nxt;
  logic [IdxW-1:0]    i_r, i_nxt;
  logic               busy_r, busy_nxt, done_r, done_nxt;
  logic signed [35:0] x0, dx, dy, xr, yr;
  logic [15:0]        a;
  logic signed [32:0] at;

  always_comb begin
    x0 = 36'(req.radius) * 36'sd39797;
    a  = req.angle;
    if (req.angle[15:14] == 2'd1 || req.angle[15:14] == 2'd2) begin
      x0 = -x0;
      a  = req.angle + 16'h8000;
    end
    dx = y_r >>> i_r;
    dy = x_r >>> i_r;
    at = 33'(atan_lut(i_r));
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; i_nxt = i_r;
    busy_nxt = busy_r; done_nxt = done_r;
    if (req.start) begin
      x_nxt = x0; y_nxt = '0; z_nxt = {a[15], a, 16'd0};
      i_nxt = '0; busy_nxt = 1'b1; done_nxt = 1'b0;
    end else if (busy_r) begin
      if (!z_r[32]) begin
        x_nxt = x_r - dx; y_nxt = y_r + dy; z_nxt = z_r - at;
      end else begin
        x_nxt = x_r + dx; y_nxt = y_r - dy; z_nxt = z_r + at;
      end
      i_nxt = i_r + 1'b1;
      if (i_r == IdxW'(CordicSteps - 1)) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
    xr = (x_r + 36'sd32768) >>> 16;
    yr = (y_r + 36'sd32768) >>> 16;
    rsp.done = done_r;
    rsp.x = xr[21:0];
    rsp.y = yr[21:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; i_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; i_r <= i_nxt;
    end
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt;
  end
endmodule

// ===== rtl/spg_divider.sv =====
// Restoring divider for the Q8.8 radius ratio, one quotient bit per cycle.
// No package dependency beyond plain logic.
module spg_divider (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] num,
  input  logic [15:0] den,
  output logic        done,
  output logic [15:0] ratio
);
  logic [23:0] q_r, q_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [15:0] den_r, den_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [17:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; den_nxt = den_r; cnt_nxt = cnt_r;
    busy_nxt = busy_r; done_nxt = 1'b0;
    trial = {rem_r, q_r[23]} - {2'b0, den_r};
    if (start) begin
      q_nxt = {num, 8'd0}; rem_nxt = '0; den_nxt = den;
      cnt_nxt = '0; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[17]) begin
        rem_nxt = trial[16:0]; q_nxt = {q_r[22:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[15:0], q_r[23]}; q_nxt = {q_r[22:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'd23) begin
        busy_nxt = 1'b0; done_nxt = 1'b1;
      end
    end
  end

  assign done  = done_r;
  assign ratio = (den_r == 16'd0 || q_r[23:16] != 8'd0) ? 16'hFFFF : q_r[15:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt; cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt; den_r <= den_nxt;
  end
endmodule

// ===== rtl/spirograph_point_generator.sv =====
// Channel  Direction  Payload
// in       input      parent_x, parent_y
// out      output     point_kind, pen_number, point_x, point_y, last_point
// cfg      input      8 registers by index, write only
// First word shows after accept: angle advance, then the ratio divide with the centre
// rotation alongside, then the phase multiply, then the load into the output register.
// Each pen word follows its own rotation and load; the input is ready again only
// the cycle after the last word is taken, so a new tick waits for all three words.
// Each of the three words waits in the output register until taken.
// Synchronous active-low reset clears angle and phases and sets the config registers to defaults.
// Depends on spg_pkg, spg_cordic, spg_divider.
module spirograph_point_generator import spg_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [19:0] in_parent_x,
  input  logic signed [19:0] in_parent_y,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_point_kind,
  output logic               out_pen_number,
  output logic signed [19:0] out_point_x,
  output logic signed [19:0] out_point_y,
  output logic               out_last_point,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  logic        mode_r;
  logic [15:0] r1_r, r2_r, pra_r, prb_r;
  logic signed [15:0] cs_r, ps_r, sf_r;
  logic [15:0] ang_r, ang_nxt;
  logic [15:0] ph_r [NumPens];
  logic [15:0] ph_nxt [NumPens];
  logic signed [19:0] px_r, py_r, px_nxt, py_nxt;
  logic signed [23:0] cx_r, cy_r, cx_nxt, cy_nxt;
  logic signed [47:0] prod_r, prod_nxt;
  logic [15:0] pd_r, pd_nxt;
  logic [1:0]  sel_r, sel_nxt;
  logic        rot_go_r, rot_go_nxt, div_go_r, div_go_nxt;
  state_t      st_r, st_nxt;
  logic        ov_r, ov_nxt, okind_r, okind_nxt, open_r, open_nxt, olast_r, olast_nxt;
  logic signed [19:0] ox_r, oy_r, ox_nxt, oy_nxt;
  rot_req_t    rq;
  rot_rsp_t    rs;
  logic        div_done;
  logic [15:0] ratio;
  logic signed [16:0] ssum;
  logic signed [32:0] sprod;
  logic signed [47:0] pdw;
  logic signed [23:0] tx, ty;

  spg_cordic u_cordic (.clk(clk), .rst_n(rst_n), .req(rq), .rsp(rs));
  spg_divider u_div (.clk(clk), .rst_n(rst_n), .start(div_go_r), .num(r1_r),
                     .den(r2_r), .done(div_done), .ratio(ratio));

  always_comb begin
    st_nxt = st_r; ang_nxt = ang_r; ph_nxt = ph_r;
    px_nxt = px_r; py_nxt = py_r; cx_nxt = cx_r; cy_nxt = cy_r;
    prod_nxt = prod_r; pd_nxt = pd_r; sel_nxt = sel_r;
    rot_go_nxt = 1'b0; div_go_nxt = 1'b0;
    ov_nxt = ov_r; okind_nxt = okind_r; open_nxt = open_r; olast_nxt = olast_r;
    ox_nxt = ox_r; oy_nxt = oy_r;
    in_ready = (st_r == ST_IDLE) && !ov_r;
    ssum  = 17'(cs_r) + 17'(ps_r);
    sprod = 33'(sf_r) * 33'(ssum);
    pdw   = 48'($signed(prod_r[31:0])) * 48'($signed({1'b0, ratio}));
    tx = cx_r + 24'(rs.x);
    ty = cy_r + 24'(rs.y);
    rq.start  = rot_go_r;
    rq.radius = (sel_r == 2'd0) ? (mode_r ? {2'b0, r1_r} - {2'b0, r2_r}
                                          : {2'b0, r1_r} + {2'b0, r2_r})
                                : {2'b0, (sel_r == 2'd1) ? pra_r : prb_r};
    rq.angle  = (sel_r == 2'd0) ? ang_r : ang_r + ph_r[sel_r[0] ? 0 : 1];
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          px_nxt = in_parent_x; py_nxt = in_parent_y; st_nxt = ST_ADV;
        end
      end
      ST_ADV: begin
        if ((cs_r < 0 && ps_r > 0) || (cs_r > 0 && ps_r < 0))
          ang_nxt = cs_r - ps_r;
        else
          ang_nxt = 16'((sprod + 33'sd2048) >>> 12);
        ang_nxt = ang_r + ang_nxt;
        sel_nxt = 2'd0; rot_go_nxt = 1'b1; div_go_nxt = 1'b1;
        prod_nxt = 48'(32'(sf_r) * 32'(cs_r));
        cx_nxt = 24'(px_r); cy_nxt = 24'(py_r);
        st_nxt = ST_DIV;
      end
      ST_DIV: if (div_done) st_nxt = ST_PD1;
      ST_PD1: begin
        prod_nxt = pdw;
        st_nxt = ST_PD2;
      end
      ST_PD2: begin
        pd_nxt = 16'((prod_r + 48'sd524288) >>> 20);
        st_nxt = ST_ROT;
      end
      ST_ROT: begin
        if (rs.done && !rot_go_r) st_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!ov_nxt) begin
          ov_nxt = 1'b1;
          ox_nxt = sat20(tx); oy_nxt = sat20(ty);
          okind_nxt = (sel_r != 2'd0);
          open_nxt  = (sel_r == 2'd2);
          olast_nxt = (sel_r == 2'd2);
          if (sel_r == 2'd0) begin
            cx_nxt = tx; cy_nxt = ty;
          end
          if (sel_r == 2'd2) begin
            st_nxt = ST_IDLE;
          end else begin
            ph_nxt[sel_r[0]] = ph_r[sel_r[0]] + pd_r;
            sel_nxt = sel_r + 2'd1; rot_go_nxt = 1'b1; st_nxt = ST_ROT;
          end
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign out_valid      = ov_r;
  assign out_point_kind = okind_r;
  assign out_pen_number = open_r;
  assign out_point_x    = ox_r;
  assign out_point_y    = oy_r;
  assign out_last_point = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE; ov_r <= 1'b0; rot_go_r <= 1'b0; div_go_r <= 1'b0;
      ang_r <= '0; ph_r <= '{default: '0}; sel_r <= '0;
      mode_r <= 1'b0; r1_r <= '0; r2_r <= 16'd1; cs_r <= '0; ps_r <= '0;
      sf_r <= 16'sd4096; pra_r <= '0; prb_r <= '0;
    end else begin
      st_r <= st_nxt; ov_r <= ov_nxt; rot_go_r <= rot_go_nxt; div_go_r <= div_go_nxt;
      ang_r <= ang_nxt; ph_r <= ph_nxt; sel_r <= sel_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MODE_INSIDE:   mode_r <= cfg_data[0];
          CFG_PARENT_RADIUS: r1_r <= cfg_data;
          CFG_CHILD_RADIUS:  r2_r <= cfg_data;
          CFG_CHILD_SPEED:   cs_r <= cfg_data;
          CFG_PARENT_SPEED:  ps_r <= cfg_data;
          CFG_SPEED_FACTOR:  sf_r <= cfg_data;
          CFG_PEN_RADIUS_A:  pra_r <= cfg_data;
          CFG_PEN_RADIUS_B:  prb_r <= cfg_data;
          default: ;
        endcase
      end
    end
    px_r <= px_nxt; py_r <= py_nxt; cx_r <= cx_nxt; cy_r <= cy_nxt;
    prod_r <= prod_nxt; pd_r <= pd_nxt;
    okind_r <= okind_nxt; open_r <= open_nxt; olast_r <= olast_nxt;
    ox_r <= ox_nxt; oy_r <= oy_nxt;
  end
endmodule

// ===== rtl/spg_checker.sv =====
// Port-level checker for the spirograph point generator, bound to the top.
// Depends on spirograph_point_generator_defines.svh.
`include "spirograph_point_generator_defines.svh"
module spg_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_point_kind,
  input logic out_pen_number,
  input logic out_last_point
);
  `SPG_ASSERT_IMPL(a_busy_no_in, clk, rst_n, out_valid, !in_ready, "ready while word pending")
  `SPG_ASSERT_IMPL(a_last_pen, clk, rst_n, out_valid && out_last_point, out_point_kind && out_pen_number, "last word not pen 1")
  `SPG_ASSERT_IMPL(a_centre_pen0, clk, rst_n, out_valid && !out_point_kind, !out_pen_number && !out_last_point, "centre word tagged as pen")
  `SPG_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_point_kind), "word dropped under stall")
endmodule

bind spirograph_point_generator spg_checker u_spg_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_point_kind(out_point_kind),
  .out_pen_number(out_pen_number), .out_last_point(out_last_point)
);

// ===== test/spirograph_point_generator_tb.sv =====
// Testbench for spirograph_point_generator: directed and random wheel ticks
// checked word by word against an in-bench fixed-point wheel predictor.
// Depends on spg_pkg and the RTL of the generator.
`timescale 1ns / 100ps

module spirograph_point_generator_tb;
  import spg_pkg::*;

  typedef struct {
    logic              kind;
    logic              pen;
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic              last;
  } point_t;

  typedef struct {
    logic signed [19:0] px;
    logic signed [19:0] py;
    bit                 has_exp;
    logic signed [19:0] ex;
    logic signed [19:0] ey;
  } tick_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [19:0] in_parent_x;
  logic signed [19:0] in_parent_y;
  logic out_valid;
  logic out_ready;
  logic out_point_kind;
  logic out_pen_number;
  logic signed [19:0] out_point_x;
  logic signed [19:0] out_point_y;
  logic out_last_point;
  logic cfg_we;
  logic [3:0] cfg_index;
  logic [15:0] cfg_data;

  spirograph_point_generator dut (.*);

  localparam int WatchdogLimit = 20000;
  localparam longint AtanTab[18] = '{
    536870912, 316933406, 167458908, 85004756, 42667338, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215
  };

  logic        m_inside;
  logic [15:0] m_r1;
  logic [15:0] m_r2;
  logic signed [15:0] m_cs;
  logic signed [15:0] m_ps;
  logic signed [15:0] m_sf;
  logic [15:0] m_pen_r[2];
  logic [15:0] m_angle;
  logic [15:0] m_phase[2];

  point_t pending_points[$];
  tick_row_t directed_rows[$];
  int errors;
  int ticks_sent;
  int words_seen;
  int idle_cycles;
  bit hold_off;
  bit rx_long_stall;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_shr(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic logic signed [19:0] clamp20(longint v);
    if (v > 524287) return 20'sd524287;
    if (v < -524288) return -20'sd524288;
    return v[19:0];
  endfunction

  task automatic rotate_vec(input longint r, input logic [15:0] ang,
                            output longint ox, output longint oy);
    logic [15:0] a;
    longint x, y, z, dx, dy;
    a = ang;
    x = r * 39797;
    y = 0;
    if (a[15:14] == 2'd1 || a[15:14] == 2'd2) begin
      x = -x;
      a = a + 16'h8000;
    end
    z = longint'($signed(a)) * 65536;
    for (int i = 0; i < 18; i++) begin
      dx = floor_shr(y, i);
      dy = floor_shr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= AtanTab[i];
      end else begin
        x += dx; y -= dy; z += AtanTab[i];
      end
    end
    ox = round_shr(x, 16);
    oy = round_shr(y, 16);
  endtask

  task automatic predict_tick(input logic signed [19:0] px, input logic signed [19:0] py);
    longint cs, ps, sf, d, crad, ox, oy, cx, cy, ratio, pd, qx, qy;
    point_t p;
    cs = m_cs; ps = m_ps; sf = m_sf;
    if ((cs < 0 && ps > 0) || (cs > 0 && ps < 0)) d = cs - ps;
    else d = round_shr(sf * (cs + ps), 12);
    m_angle = m_angle + d[15:0];
    crad = m_inside ? longint'(m_r1) - longint'(m_r2) : longint'(m_r1) + longint'(m_r2);
    rotate_vec(crad, m_angle, ox, oy);
    cx = longint'(px) + ox;
    cy = longint'(py) + oy;
    p = '{1'b0, 1'b0, clamp20(cx), clamp20(cy), 1'b0};
    pending_points.push_back(p);
    if (m_r2 == 0) ratio = 65535;
    else begin
      ratio = (longint'(m_r1) * 256) / longint'(m_r2);
      if (ratio > 65535) ratio = 65535;
    end
    pd = round_shr(sf * cs * ratio, 20);
    for (int k = 0; k < 2; k++) begin
      m_phase[k] = m_phase[k] + pd[15:0];
      rotate_vec(longint'(m_pen_r[k]), m_angle + m_phase[k], qx, qy);
      p = '{1'b1, 1'(k), clamp20(cx + qx), clamp20(cy + qy), 1'(k == 1)};
      pending_points.push_back(p);
    end
  endtask

  task automatic report_mismatch(input string what);
    errors++;
    $display("MISMATCH word %0d: %s", words_seen, what);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [15:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_MODE_INSIDE:   m_inside = val[0];
      CFG_PARENT_RADIUS: m_r1 = val;
      CFG_CHILD_RADIUS:  m_r2 = val;
      CFG_CHILD_SPEED:   m_cs = val;
      CFG_PARENT_SPEED:  m_ps = val;
      CFG_SPEED_FACTOR:  m_sf = val;
      CFG_PEN_RADIUS_A:  m_pen_r[0] = val;
      CFG_PEN_RADIUS_B:  m_pen_r[1] = val;
      default: ;
    endcase
  endtask

  task automatic set_wheels(input logic ins, input logic [15:0] r1, input logic [15:0] r2,
                            input logic [15:0] cs, input logic [15:0] ps,
                            input logic [15:0] sf, input logic [15:0] pa,
                            input logic [15:0] pb);
    write_reg(CFG_MODE_INSIDE, {15'd0, ins});
    write_reg(CFG_PARENT_RADIUS, r1);
    write_reg(CFG_CHILD_RADIUS, r2);
    write_reg(CFG_CHILD_SPEED, cs);
    write_reg(CFG_PARENT_SPEED, ps);
    write_reg(CFG_SPEED_FACTOR, sf);
    write_reg(CFG_PEN_RADIUS_A, pa);
    write_reg(CFG_PEN_RADIUS_B, pb);
  endtask

  task automatic drain;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic send_tick(input logic signed [19:0] px, input logic signed [19:0] py);
    int gap;
    gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
    if ($urandom_range(0, 3) == 0) gap = 1;
    repeat (gap) @(posedge clk);
    predict_tick(px, py);
    in_valid <= 1'b1;
    in_parent_x <= px;
    in_parent_y <= py;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    ticks_sent++;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      point_t e;
      words_seen++;
      if (pending_points.size() == 0) report_mismatch("word with nothing expected");
      else begin
        e = pending_points.pop_front();
        if (out_point_kind !== e.kind) report_mismatch("point_kind");
        if (out_pen_number !== e.pen) report_mismatch("pen_number");
        if (out_point_x !== e.x)
          report_mismatch($sformatf("point_x %0d exp %0d", out_point_x, e.x));
        if (out_point_y !== e.y)
          report_mismatch($sformatf("point_y %0d exp %0d", out_point_y, e.y));
        if (out_last_point !== e.last) report_mismatch("last_point");
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (rx_long_stall) begin
        out_ready <= 1'b0;
        repeat (600) @(posedge clk);
        rx_long_stall = 1'b0;
      end else if (hold_off) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 19) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(5, 40)) @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d words outstanding", pending_points.size());
      $display("spirograph_point_generator_tb failed");
      $finish;
    end
  end

  initial begin
    tick_row_t row;
    point_t chk;
    errors = 0; ticks_sent = 0; words_seen = 0; idle_cycles = 0;
    hold_off = 1'b0; rx_long_stall = 1'b0;
    rst_n <= 1'b0;
    in_valid <= 1'b0; in_parent_x <= '0; in_parent_y <= '0;
    cfg_we <= 1'b0; cfg_index <= '0; cfg_data <= '0;
    m_inside = 0; m_r1 = 0; m_r2 = 1; m_cs = 0; m_ps = 0; m_sf = 16'sd4096;
    m_pen_r[0] = 0; m_pen_r[1] = 0; m_angle = 0; m_phase[0] = 0; m_phase[1] = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // after reset: centre offset by child radius 1 at angle 0
    directed_rows.push_back('{20'sd0, 20'sd0, 1'b1, 20'sd1, 20'sd0});
    directed_rows.push_back('{20'sd524287, 20'sd524287, 1'b1, 20'sd524287, 20'sd524287});
    directed_rows.push_back('{-20'sd524288, -20'sd524288, 1'b1, -20'sd524287, -20'sd524288});
    directed_rows.push_back('{20'sd12345, -20'sd54321, 1'b1, 20'sd12346, -20'sd54321});
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      send_tick(row.px, row.py);
      if (row.has_exp) begin
        chk = pending_points[pending_points.size() - 3];
        if (chk.x !== row.ex || chk.y !== row.ey)
          report_mismatch("directed table vs predictor");
        chk.x = row.ex;
        chk.y = row.ey;
        pending_points[pending_points.size() - 3] = chk;
      end
    end
    drain();

    // extremes: inside mode with child bigger than parent, large pens, opposite speeds
    set_wheels(1, 16'd100, 16'd65535, 16'h8000, 16'h7fff, 16'h8000, 16'hffff, 16'hffff);
    for (int i = 0; i < 5; i++) send_tick(20'sd524287 - 20'(i), -20'sd524288 + 20'(i));
    drain();
    // zero child radius saturates the ratio; same-sign speeds use the factor
    set_wheels(0, 16'hffff, 16'd0, 16'h7fff, 16'h7fff, 16'h7fff, 16'd0, 16'd4000);
    for (int i = 0; i < 5; i++) send_tick(20'sd0, 20'sd0);
    drain();
    set_wheels(0, 16'd0, 16'd1, 16'hffff, 16'hffff, 16'hf000, 16'd1, 16'd0);
    for (int i = 0; i < 4; i++) send_tick(-20'sd1, 20'sd1);
    drain();
    write_reg(CFG_CHILD_SPEED, 16'd0);
    write_reg(CFG_PARENT_SPEED, 16'h8000);
    for (int i = 0; i < 3; i++) send_tick(20'sd77, -20'sd77);
    drain();

    for (int phase = 0; phase < 4; phase++) begin
      logic [15:0] r1;
      r1 = $urandom_range(0, 1) ? 16'($urandom_range(0, 4000)) : 16'($urandom);
      set_wheels(1'($urandom), r1, 16'($urandom_range(1, 3000)), 16'($urandom),
                 16'($urandom), 16'($urandom), 16'($urandom_range(0, 2000)),
                 16'($urandom));
      if (phase == 1) rx_long_stall = 1'b1;
      for (int i = 0; i < 20; i++) send_tick(20'($urandom), 20'($urandom));
      if (phase == 2) begin
        hold_off = 1'b1;
        while (pending_points.size() != 0) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end

    $display("ran %0d wheel ticks, %0d words checked, all registers swept incl. extremes",
             ticks_sent, words_seen);
    if (errors == 0 && pending_points.size() == 0)
      $display("spirograph_point_generator_tb passed");
    else
      $display("spirograph_point_generator_tb failed");
    $finish;
  end
endmodule
